[hw/rtl/ambiguous_base_position_stats_macros.svh]
// Assertion macros used by the ambiguous-base statistics top level
`ifndef AMBIGUOUS_BASE_POSITION_STATS_MACROS_SVH
`define AMBIGUOUS_BASE_POSITION_STATS_MACROS_SVH

// Same-cycle implication, clocked on i_clk, off during reset
`define ABPS_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, clocked on i_clk, off during reset
`define ABPS_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hw/rtl/abps_pkg.sv]
// Shared types and constants for the ambiguous-base statistics block
package abps_pkg;

    localparam int READ_LEN_DEF    = 64;
    localparam int TABLE_DEPTH_DEF = 32;
    localparam int COUNT_WIDTH_DEF = 40;

    localparam int BITMAP_W   = 64;
    localparam int SLOT_W     = 6;
    localparam int SLOT_OUT_W = 5;
    localparam int USED_W     = 7;
    localparam int LEN_W      = 7;
    localparam int POS_W      = 6;
    localparam int OUT_CNT_W  = 40;
    localparam int IN_DATA_W  = 16;
    localparam int OUT_DATA_W = 280;

    localparam logic [7:0] BASE_N = 8'd78;

    typedef enum logic [1:0] {
        REQ_CHAR = 2'd0,
        REQ_HIST = 2'd1,
        REQ_PAT  = 2'd2,
        REQ_NONE = 2'd3
    } t_req;

    typedef enum logic [1:0] {
        KIND_EOR  = 2'd0,
        KIND_HIST = 2'd1,
        KIND_PAT  = 2'd2
    } t_kind;

    typedef enum logic [1:0] {
        MS_NO_N   = 2'd0,
        MS_MATCH  = 2'd1,
        MS_STORED = 2'd2,
        MS_FULL   = 2'd3
    } t_match;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_SEARCH,
        ST_OUT
    } t_state;

    // Control bits of the search token walking the table cells
    typedef struct packed {
        logic valid;
        logic op_read;
        logic found;
    } t_tok_ctl;

endpackage

[hw/rtl/ambiguous_base_position_stats.sv]
// Top level of the ambiguous-base position statistics block
// Characters arrive one per transfer, grouped into reads of read_length (0 acts as 1, above
// READ_LEN as READ_LEN). A character that does not close a read is accepted, then an N makes a
// histogram read-modify-write on the single-port position memory. A histogram readout goes
// through execute and output. A closing character of a read that holds N, and a pattern readout,
// launch a search token that walks the row of table cells one cell per cycle. A closing
// character without N goes straight to output. Results leave through an output register, so the
// next item is accepted while a result still waits. The position histogram is cleared at reset
// through per-entry valid bits, so no clearing pass is needed.
`include "ambiguous_base_position_stats_macros.svh"

module ambiguous_base_position_stats import abps_pkg::*; #(
    parameter int READ_LEN    = READ_LEN_DEF,
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [LEN_W-1:0]      i_cfg_wdata,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // base [7:0], index [13:8], zero [15:14]
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    // req_type [1:0]
    input  logic [1:0]            s_axis_tuser,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // read_n_count [6:0], match_status [8:7], slot [13:9], position_count [53:14],
    // pattern_bits [117:54], pattern_reads [157:118], slot_valid [158], total_n [198:159],
    // total_reads [238:199], reads_with_n [278:239], zero [279]
    output logic [OUT_DATA_W-1:0] m_axis_tdata,
    // kind [1:0]
    output logic [1:0]            m_axis_tuser
);

    localparam int HAW = (READ_LEN > 1) ? $clog2(READ_LEN) : 1;
    localparam logic [COUNT_WIDTH-1:0] CNT_MAX  = '1;
    localparam logic [LEN_W-1:0]       LEN_MAX  = LEN_W'(READ_LEN);
    localparam logic [USED_W-1:0]      USED_MAX = USED_W'(TABLE_DEPTH);

    // Control and configuration state
    t_state                 r_state, n_state;
    logic [LEN_W-1:0]       r_rlen;
    t_req                   r_req;
    logic [7:0]             r_base;
    logic [SLOT_W-1:0]      r_idx;
    logic [LEN_W-1:0]       r_pos;
    logic [POS_W-1:0]       r_cpos;
    logic [BITMAP_W-1:0]    r_bitmap;
    logic [LEN_W-1:0]       r_ncount;
    logic [USED_W-1:0]      r_used;
    logic [COUNT_WIDTH-1:0] r_ntot;
    logic [COUNT_WIDTH-1:0] r_rtot;
    logic [COUNT_WIDTH-1:0] r_nrtot;

    // Result being built
    t_kind                  r_rs_kind;
    logic [LEN_W-1:0]       r_rs_ncount;
    t_match                 r_rs_status;
    logic [SLOT_OUT_W-1:0]  r_rs_slot;
    logic [OUT_CNT_W-1:0]   r_rs_pcount;
    logic [BITMAP_W-1:0]    r_rs_bits;
    logic [OUT_CNT_W-1:0]   r_rs_reads;
    logic                   r_rs_valid;

    // Output register
    logic                   r_m_valid;
    logic [OUT_DATA_W-1:0]  r_m_data;
    logic [1:0]             r_m_user;

    // Histogram memory
    logic [COUNT_WIDTH-1:0] r_hist [READ_LEN];
    logic [READ_LEN-1:0]    r_hvalid;
    logic [COUNT_WIDTH-1:0] r_hrd;
    logic                   r_hrd_v;

    // Handshake and control strobes
    logic                   w_accept;
    logic                   w_load_out;
    logic                   w_launch;
    logic                   w_tbl_wr;
    logic                   w_search_done;

    logic [LEN_W-1:0]       w_cpos_ext;
    logic [LEN_W-1:0]       w_pos_cl;
    logic [LEN_W-1:0]       w_len;
    logic                   w_end;
    logic                   w_is_n;
    logic [HAW-1:0]         w_raddr;
    logic [COUNT_WIDTH-1:0] w_hrd_eff;
    logic [COUNT_WIDTH-1:0] w_hist_new;
    logic                   w_hist_we;
    logic [BITMAP_W-1:0]    w_bitmap_new;
    logic [LEN_W-1:0]       w_ncount_new;
    logic [COUNT_WIDTH:0]   w_ntot_sum;
    logic                   w_idx_in_hist;

    logic [COUNT_WIDTH+OUT_CNT_W-1:0] w_hrd_x;
    logic [COUNT_WIDTH+OUT_CNT_W-1:0] w_tok_cnt_x;
    logic [COUNT_WIDTH+OUT_CNT_W-1:0] w_ntot_x;
    logic [COUNT_WIDTH+OUT_CNT_W-1:0] w_rtot_x;
    logic [COUNT_WIDTH+OUT_CNT_W-1:0] w_nrtot_x;

    // Token chain through the table cells
    t_tok_ctl               w_ctl  [TABLE_DEPTH+1];
    logic [BITMAP_W-1:0]    w_bits [TABLE_DEPTH+1];
    logic [SLOT_W-1:0]      w_idx  [TABLE_DEPTH+1];
    logic [SLOT_W-1:0]      w_slot [TABLE_DEPTH+1];
    logic [COUNT_WIDTH-1:0] w_cnt  [TABLE_DEPTH+1];

    // Position, length and character decode
    always_comb begin
        w_cpos_ext    = LEN_W'(r_cpos);
        w_pos_cl      = (w_cpos_ext >= LEN_MAX) ? LEN_MAX - LEN_W'(1) : w_cpos_ext;
        w_len         = (r_rlen == '0) ? LEN_W'(1) : ((r_rlen > LEN_MAX) ? LEN_MAX : r_rlen);
        w_end         = (r_pos + LEN_W'(1)) >= w_len;
        w_is_n        = (r_base == BASE_N);
        w_raddr       = (t_req'(s_axis_tuser) == REQ_CHAR) ? w_pos_cl[HAW-1:0]
                                                           : s_axis_tdata[8 +: HAW];
        w_idx_in_hist = LEN_W'(r_idx) < LEN_MAX;
        w_hrd_eff     = r_hrd_v ? r_hrd : '0;
        w_hist_new    = (w_hrd_eff == CNT_MAX) ? w_hrd_eff : w_hrd_eff + COUNT_WIDTH'(1);
        w_bitmap_new  = w_is_n ? (r_bitmap | (BITMAP_W'(1) << r_pos[POS_W-1:0])) : r_bitmap;
        w_ncount_new  = (w_is_n && (r_ncount < LEN_W'(64))) ? r_ncount + LEN_W'(1) : r_ncount;
        w_ntot_sum    = {1'b0, r_ntot} + (COUNT_WIDTH+1)'(w_ncount_new);
        w_hrd_x       = {{OUT_CNT_W{1'b0}}, w_hrd_eff};
        w_tok_cnt_x   = {{OUT_CNT_W{1'b0}}, w_cnt[TABLE_DEPTH]};
        w_ntot_x      = {{OUT_CNT_W{1'b0}}, r_ntot};
        w_rtot_x      = {{OUT_CNT_W{1'b0}}, r_rtot};
        w_nrtot_x     = {{OUT_CNT_W{1'b0}}, r_nrtot};
        w_search_done = w_ctl[TABLE_DEPTH].valid;
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (s_axis_tvalid) n_state = ST_EXEC;
            end
            ST_EXEC: begin
                unique case (r_req)
                    REQ_CHAR: begin
                        if (!w_end) begin
                            n_state = ST_IDLE;
                        end else if (w_ncount_new != '0) begin
                            n_state = ST_SEARCH;
                        end else begin
                            n_state = ST_OUT;
                        end
                    end
                    REQ_HIST: n_state = ST_OUT;
                    REQ_PAT:  n_state = ST_SEARCH;
                    default:  n_state = ST_IDLE;
                endcase
            end
            ST_SEARCH: begin
                if (w_search_done) n_state = ST_OUT;
            end
            ST_OUT: begin
                if (!r_m_valid || m_axis_tready) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Control strobes
    always_comb begin
        s_axis_tready = (r_state == ST_IDLE);
        w_accept      = s_axis_tvalid && s_axis_tready;
        w_load_out    = (r_state == ST_OUT) && (!r_m_valid || m_axis_tready);
        w_hist_we     = (r_state == ST_EXEC) && (r_req == REQ_CHAR) && w_is_n;
        w_launch      = (r_state == ST_EXEC) && ((r_req == REQ_PAT)
                        || ((r_req == REQ_CHAR) && w_end && (w_ncount_new != '0)));
        w_tbl_wr      = (r_state == ST_SEARCH) && w_search_done && !w_ctl[TABLE_DEPTH].op_read
                        && !w_ctl[TABLE_DEPTH].found && (r_used < USED_MAX);
    end

    // Token entry into the first cell
    always_comb begin
        w_ctl[0].valid   = w_launch;
        w_ctl[0].op_read = (r_req == REQ_PAT);
        w_ctl[0].found   = 1'b0;
        w_bits[0]        = (r_req == REQ_PAT) ? '0 : w_bitmap_new;
        w_idx[0]         = r_idx;
        w_slot[0]        = '0;
        w_cnt[0]         = '0;
    end

    // Row of table cells
    for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
        abps_cell #(
            .CELL_IDX    (g),
            .COUNT_WIDTH (COUNT_WIDTH)
        ) u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_ctl        (w_ctl[g]),
            .i_bits       (w_bits[g]),
            .i_idx        (w_idx[g]),
            .i_slot       (w_slot[g]),
            .i_cnt        (w_cnt[g]),
            .i_slots_used (r_used),
            .i_wr_en      (w_tbl_wr),
            .i_wr_slot    (r_used[SLOT_W-1:0]),
            .i_wr_bits    (r_rs_bits),
            .o_ctl        (w_ctl[g+1]),
            .o_bits       (w_bits[g+1]),
            .o_idx        (w_idx[g+1]),
            .o_slot       (w_slot[g+1]),
            .o_cnt        (w_cnt[g+1])
        );
    end

    // Histogram memory: registered read on accept, write in execute
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_hrd <= r_hist[w_raddr];
        end
        if (w_hist_we) begin
            r_hist[r_pos[HAW-1:0]] <= w_hist_new;
        end
    end

    // Histogram entry valid bits, cleared at reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hvalid <= '0;
            r_hrd_v  <= 1'b0;
        end else begin
            if (w_accept) r_hrd_v <= r_hvalid[w_raddr];
            if (w_hist_we) r_hvalid[r_pos[HAW-1:0]] <= 1'b1;
        end
    end

    // Item capture
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_req  <= t_req'(s_axis_tuser);
            r_base <= s_axis_tdata[7:0];
            r_idx  <= s_axis_tdata[13:8];
            r_pos  <= w_pos_cl;
        end
    end

    // State, read tracking, table fill and totals
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_rlen   <= LEN_W'(64);
            r_cpos   <= '0;
            r_bitmap <= '0;
            r_ncount <= '0;
            r_used   <= '0;
            r_ntot   <= '0;
            r_rtot   <= '0;
            r_nrtot  <= '0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) r_rlen <= i_cfg_wdata;
            if ((r_state == ST_EXEC) && (r_req == REQ_CHAR)) begin
                if (!w_end) begin
                    r_cpos   <= r_pos[POS_W-1:0] + POS_W'(1);
                    r_bitmap <= w_bitmap_new;
                    r_ncount <= w_ncount_new;
                end else begin
                    r_cpos   <= '0;
                    r_bitmap <= '0;
                    r_ncount <= '0;
                    r_rtot   <= (r_rtot == CNT_MAX) ? r_rtot : r_rtot + COUNT_WIDTH'(1);
                    if (w_ncount_new != '0) begin
                        r_ntot  <= w_ntot_sum[COUNT_WIDTH] ? CNT_MAX
                                                           : w_ntot_sum[COUNT_WIDTH-1:0];
                        r_nrtot <= (r_nrtot == CNT_MAX) ? r_nrtot
                                                        : r_nrtot + COUNT_WIDTH'(1);
                    end
                end
            end
            if (w_tbl_wr) r_used <= r_used + USED_W'(1);
        end
    end

    // Result assembly
    always_ff @(posedge i_clk) begin
        if (r_state == ST_EXEC) begin
            r_rs_ncount <= '0;
            r_rs_status <= MS_NO_N;
            r_rs_slot   <= '0;
            r_rs_pcount <= '0;
            r_rs_bits   <= '0;
            r_rs_reads  <= '0;
            r_rs_valid  <= 1'b0;
            unique case (r_req)
                REQ_CHAR: begin
                    r_rs_kind   <= KIND_EOR;
                    r_rs_ncount <= w_ncount_new;
                    r_rs_bits   <= w_bitmap_new;
                end
                REQ_HIST: begin
                    r_rs_kind   <= KIND_HIST;
                    r_rs_pcount <= w_idx_in_hist ? w_hrd_x[OUT_CNT_W-1:0] : '0;
                end
                REQ_PAT: begin
                    r_rs_kind <= KIND_PAT;
                    r_rs_slot <= r_idx[SLOT_OUT_W-1:0];
                end
                default: r_rs_kind <= KIND_EOR;
            endcase
        end else if ((r_state == ST_SEARCH) && w_search_done) begin
            if (w_ctl[TABLE_DEPTH].op_read) begin
                if (w_ctl[TABLE_DEPTH].found) begin
                    r_rs_bits  <= w_bits[TABLE_DEPTH];
                    r_rs_reads <= w_tok_cnt_x[OUT_CNT_W-1:0];
                    r_rs_valid <= 1'b1;
                end
            end else if (w_ctl[TABLE_DEPTH].found) begin
                r_rs_status <= MS_MATCH;
                r_rs_slot   <= w_slot[TABLE_DEPTH][SLOT_OUT_W-1:0];
                r_rs_reads  <= w_tok_cnt_x[OUT_CNT_W-1:0];
                r_rs_valid  <= 1'b1;
            end else if (r_used < USED_MAX) begin
                r_rs_status <= MS_STORED;
                r_rs_slot   <= r_used[SLOT_OUT_W-1:0];
                r_rs_reads  <= OUT_CNT_W'(1);
                r_rs_valid  <= 1'b1;
            end else begin
                r_rs_status <= MS_FULL;
            end
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (w_load_out) begin
            r_m_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load_out) begin
            r_m_user <= r_rs_kind;
            r_m_data <= {1'b0,
                         w_nrtot_x[OUT_CNT_W-1:0],
                         w_rtot_x[OUT_CNT_W-1:0],
                         w_ntot_x[OUT_CNT_W-1:0],
                         r_rs_valid,
                         r_rs_reads,
                         r_rs_bits,
                         r_rs_pcount,
                         r_rs_slot,
                         r_rs_status,
                         r_rs_ncount};
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;
    assign m_axis_tuser  = r_m_user;

    // Checks
    `ABPS_ASSERT_IMP(a_used_bound, 1'b1, r_used <= USED_MAX, "table fill beyond depth")
    `ABPS_ASSERT_IMP(a_tok_exit, w_search_done, r_state == ST_SEARCH, "stray search token")
    `ABPS_ASSERT_IMP(a_ncount_map, 1'b1, (r_bitmap == '0) == (r_ncount == '0), "N count vs map")
    `ABPS_ASSERT_NXT(a_table_fill, w_tbl_wr, r_used == $past(r_used) + USED_W'(1), "fill step")

endmodule

[hw/rtl/abps_cell.sv]
// One pattern table slot: stored bitmap, its read count and a token stage
module abps_cell import abps_pkg::*; #(
    parameter int CELL_IDX    = 0,
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  t_tok_ctl               i_ctl,
    input  logic [BITMAP_W-1:0]    i_bits,
    input  logic [SLOT_W-1:0]      i_idx,
    input  logic [SLOT_W-1:0]      i_slot,
    input  logic [COUNT_WIDTH-1:0] i_cnt,
    input  logic [USED_W-1:0]      i_slots_used,
    input  logic                   i_wr_en,
    input  logic [SLOT_W-1:0]      i_wr_slot,
    input  logic [BITMAP_W-1:0]    i_wr_bits,
    output t_tok_ctl               o_ctl,
    output logic [BITMAP_W-1:0]    o_bits,
    output logic [SLOT_W-1:0]      o_idx,
    output logic [SLOT_W-1:0]      o_slot,
    output logic [COUNT_WIDTH-1:0] o_cnt
);

    localparam logic [SLOT_W-1:0]      MY_SLOT = SLOT_W'(CELL_IDX);
    localparam logic [USED_W-1:0]      MY_USED = USED_W'(CELL_IDX);
    localparam logic [COUNT_WIDTH-1:0] CNT_MAX = '1;

    logic [BITMAP_W-1:0]    r_pat;
    logic [COUNT_WIDTH-1:0] r_cnt;
    t_tok_ctl               r_ctl;
    logic [BITMAP_W-1:0]    r_bits;
    logic [SLOT_W-1:0]      r_idx;
    logic [SLOT_W-1:0]      r_slot;
    logic [COUNT_WIDTH-1:0] r_tcnt;

    logic                   w_in_use;
    logic                   w_hit;
    logic                   w_rd;
    logic [COUNT_WIDTH-1:0] w_cnt_inc;

    // Match or readout decision for the passing token
    always_comb begin
        w_in_use  = MY_USED < i_slots_used;
        w_hit     = i_ctl.valid && !i_ctl.op_read && !i_ctl.found && w_in_use
                    && (r_pat == i_bits);
        w_rd      = i_ctl.valid && i_ctl.op_read && w_in_use && (i_idx == MY_SLOT);
        w_cnt_inc = (r_cnt == CNT_MAX) ? r_cnt : r_cnt + COUNT_WIDTH'(1);
    end

    // Slot contents: new pattern store or saturating count bump
    always_ff @(posedge i_clk) begin
        if (i_wr_en && (i_wr_slot == MY_SLOT)) begin
            r_pat <= i_wr_bits;
            r_cnt <= COUNT_WIDTH'(1);
        end else if (w_hit) begin
            r_cnt <= w_cnt_inc;
        end
    end

    // Token control to the next cell
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else begin
            r_ctl.valid   <= i_ctl.valid;
            r_ctl.op_read <= i_ctl.op_read;
            r_ctl.found   <= i_ctl.found || w_hit || w_rd;
        end
    end

    // Token payload to the next cell
    always_ff @(posedge i_clk) begin
        r_idx  <= i_idx;
        r_bits <= w_rd ? r_pat : i_bits;
        r_slot <= w_hit ? MY_SLOT : i_slot;
        if (w_hit) begin
            r_tcnt <= w_cnt_inc;
        end else if (w_rd) begin
            r_tcnt <= r_cnt;
        end else begin
            r_tcnt <= i_cnt;
        end
    end

    assign o_ctl  = r_ctl;
    assign o_bits = r_bits;
    assign o_idx  = r_idx;
    assign o_slot = r_slot;
    assign o_cnt  = r_tcnt;

endmodule

[verif/ambiguous_base_position_stats_checker.sv]
// Checker for the ambiguous-base statistics block: watches both streams, predicts and compares
module ambiguous_base_position_stats_checker import abps_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [LEN_W-1:0]      i_cfg_wdata,
    input  logic                  i_in_valid,
    input  logic                  i_in_ready,
    input  logic [IN_DATA_W-1:0]  i_in_data,
    input  logic [1:0]            i_in_user,
    input  logic                  i_out_valid,
    input  logic                  i_out_ready,
    input  logic [OUT_DATA_W-1:0] i_out_data,
    input  logic [1:0]            i_out_user,
    output int                    o_errors,
    output int                    o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NPOS = 64;
    localparam int NSLOT = 32;
    localparam logic [39:0] CNT_MAX = '1;

    typedef struct packed {
        logic [1:0]  kind;
        logic [6:0]  read_n_count;
        logic [1:0]  match_status;
        logic [4:0]  slot;
        logic [39:0] position_count;
        logic [63:0] pattern_bits;
        logic [39:0] pattern_reads;
        logic        slot_valid;
        logic [39:0] total_n;
        logic [39:0] total_reads;
        logic [39:0] reads_with_n;
    } t_stats_res;

    // Predicted block state
    logic [39:0] hist [NPOS];
    logic [63:0] pat_bits [NSLOT];
    logic [39:0] pat_cnt [NSLOT];
    logic [63:0] cur_map;
    int          cur_n;
    int          char_pos;
    int          used;
    int          read_len;
    logic [39:0] sum_n, sum_reads, sum_n_reads;
    t_stats_res  expected_results[$];

    function automatic logic [39:0] sat_inc(logic [39:0] a, logic [39:0] b);
        logic [40:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[40] ? CNT_MAX : s[39:0];
    endfunction

    // Work out the result of one accepted item, if any
    task automatic predict_item(logic [1:0] req, logic [7:0] base, logic [5:0] idx);
        t_stats_res r;
        int len, pos;
        bit hit;
        r = '0;
        if (req == REQ_CHAR) begin
            len = read_len < 1 ? 1 : (read_len > NPOS ? NPOS : read_len);
            pos = char_pos >= NPOS ? NPOS - 1 : char_pos;
            if (base == BASE_N) begin
                hist[pos] = sat_inc(hist[pos], 40'd1);
                cur_map[pos] = 1'b1;
                if (cur_n < 64) cur_n++;
            end
            if (pos + 1 < len) begin
                char_pos = pos + 1;
                return;
            end
            sum_reads = sat_inc(sum_reads, 40'd1);
            r.kind = KIND_EOR;
            r.match_status = MS_NO_N;
            if (cur_n > 0) begin
                hit = 0;
                sum_n = sat_inc(sum_n, 40'(cur_n));
                sum_n_reads = sat_inc(sum_n_reads, 40'd1);
                for (int i = 0; i < used; i++) begin
                    if (!hit && pat_bits[i] == cur_map) begin
                        pat_cnt[i] = sat_inc(pat_cnt[i], 40'd1);
                        hit = 1;
                        r.match_status = MS_MATCH;
                        r.slot = 5'(i);
                        r.slot_valid = 1'b1;
                        r.pattern_reads = pat_cnt[i];
                    end
                end
                if (!hit) begin
                    if (used < NSLOT) begin
                        pat_bits[used] = cur_map;
                        pat_cnt[used] = 40'd1;
                        r.match_status = MS_STORED;
                        r.slot = 5'(used);
                        r.slot_valid = 1'b1;
                        r.pattern_reads = 40'd1;
                        used++;
                    end else begin
                        r.match_status = MS_FULL;
                    end
                end
            end
            r.read_n_count = 7'(cur_n);
            r.pattern_bits = cur_map;
            cur_map = '0;
            cur_n = 0;
            char_pos = 0;
        end else if (req == REQ_HIST) begin
            r.kind = KIND_HIST;
            r.position_count = hist[idx];
        end else if (req == REQ_PAT) begin
            r.kind = KIND_PAT;
            r.slot = idx[4:0];
            if (idx < used) begin
                r.pattern_bits = pat_bits[idx];
                r.pattern_reads = pat_cnt[idx];
                r.slot_valid = 1'b1;
            end
        end else begin
            return;
        end
        r.total_n = sum_n;
        r.total_reads = sum_reads;
        r.reads_with_n = sum_n_reads;
        expected_results = {expected_results, r};
    endtask

    // Compare one field, report on mismatch
    function automatic void cmp(string name, logic [63:0] exp_v, logic [63:0] act_v);
        if (exp_v !== act_v) begin
            $error("%s: expected 0x%0h, actual 0x%0h", name, exp_v, act_v);
            o_errors++;
        end
    endfunction

    assign o_pending = expected_results.size();

    initial o_errors = 0;

    always @(posedge i_clk) begin
        t_stats_res e;
        if (!i_rst_n) begin
            for (int i = 0; i < NPOS; i++) hist[i] = '0;
            cur_map = '0;
            cur_n = 0;
            char_pos = 0;
            used = 0;
            read_len = 64;
            sum_n = '0;
            sum_reads = '0;
            sum_n_reads = '0;
            expected_results.delete();
        end else begin
            if (i_cfg_we) read_len = int'(i_cfg_wdata);
            if (i_in_valid && i_in_ready)
                predict_item(i_in_user, i_in_data[7:0], i_in_data[13:8]);
            // Result transfer checked against the oldest expectation
            if (i_out_valid && i_out_ready) begin
                if (expected_results.size() == 0) begin
                    $error("result transfer with nothing expected");
                    o_errors++;
                end else begin
                    e = expected_results.pop_front();
                    cmp("kind", 64'(e.kind), 64'(i_out_user));
                    cmp("read_n_count", 64'(e.read_n_count), 64'(i_out_data[6:0]));
                    cmp("match_status", 64'(e.match_status), 64'(i_out_data[8:7]));
                    cmp("slot", 64'(e.slot), 64'(i_out_data[13:9]));
                    cmp("position_count", 64'(e.position_count), 64'(i_out_data[53:14]));
                    cmp("pattern_bits", e.pattern_bits, i_out_data[117:54]);
                    cmp("pattern_reads", 64'(e.pattern_reads), 64'(i_out_data[157:118]));
                    cmp("slot_valid", 64'(e.slot_valid), 64'(i_out_data[158]));
                    cmp("total_n", 64'(e.total_n), 64'(i_out_data[198:159]));
                    cmp("total_reads", 64'(e.total_reads), 64'(i_out_data[238:199]));
                    cmp("reads_with_n", 64'(e.reads_with_n), 64'(i_out_data[278:239]));
                    cmp("tdata padding", 64'd0, 64'(i_out_data[279]));
                end
            end
        end
    end
endmodule

[verif/ambiguous_base_position_stats_tb.sv]
// Testbench top for the ambiguous-base statistics block: stimulus, stalls and verdict
module ambiguous_base_position_stats_tb;
    import abps_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 1500000;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_we = 1'b0;
    logic [LEN_W-1:0]      i_cfg_wdata = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
    logic [1:0]            s_axis_tuser = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic [1:0]            m_axis_tuser;
    int                    errors;
    int                    pending;
    int                    cycles = 0;
    bit                    hold_off = 0;
    int                    cur_len = 64;

    ambiguous_base_position_stats uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_wdata(i_cfg_wdata),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
    );

    ambiguous_base_position_stats_checker chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_wdata(i_cfg_wdata),
        .i_in_valid(s_axis_tvalid), .i_in_ready(s_axis_tready),
        .i_in_data(s_axis_tdata), .i_in_user(s_axis_tuser),
        .i_out_valid(m_axis_tvalid), .i_out_ready(m_axis_tready),
        .i_out_data(m_axis_tdata), .i_out_user(m_axis_tuser),
        .o_errors(errors), .o_pending(pending)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Run limit
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    function automatic int gap_len();
        int p;
        p = $urandom_range(0, 99);
        if (p < 40) return 0;
        if (p < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // Receiver: random stalls, long hold-off on request
    initial begin
        int g;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (hold_off) begin
                m_axis_tready <= 1'b0;
                for (int i = 0; i < 400; i++) @(negedge i_clk);
                hold_off = 0;
            end
            g = ($urandom_range(0, 3) == 0) ? gap_len() : 0;
            m_axis_tready <= (g == 0);
            for (int i = 1; i < g; i++) @(negedge i_clk);
        end
    end

    // One item transfer; drive at the falling edge, wait for acceptance
    task automatic send_item(logic [1:0] req, logic [7:0] base, logic [5:0] idx);
        int g;
        g = gap_len();
        if (g > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (g) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= req;
        s_axis_tdata <= {2'b00, idx, base};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (60) @(negedge i_clk);
    endtask

    task automatic set_len(int v);
        drain();
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= 7'(v);
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        cur_len = (v < 1) ? 1 : (v > 64 ? 64 : v);
    endtask

    // A read with random content; N density chosen per read
    task automatic send_read(int density);
        for (int i = 0; i < cur_len; i++)
            send_item(REQ_CHAR,
                      ($urandom_range(0, 99) < density) ? BASE_N : 8'($urandom_range(0, 255)),
                      6'($urandom));
    endtask

    initial begin
        int lens[6];
        int p;
        lens = '{1, 64, 0, 127, 5, 3};
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed: readouts at reset, three short reads, extremes of fields
        set_len(2);
        send_item(REQ_HIST, 8'd0, 6'd0);
        send_item(REQ_PAT, 8'd255, 6'd63);
        send_item(REQ_CHAR, BASE_N, 6'd0);
        send_item(REQ_CHAR, 8'd255, 6'd63);
        send_item(REQ_CHAR, 8'd0, 6'd0);
        send_item(REQ_CHAR, 8'd0, 6'd0);
        send_item(REQ_CHAR, BASE_N, 6'd0);
        send_item(REQ_CHAR, 8'd77, 6'd0);
        send_item(REQ_NONE, BASE_N, 6'd21);
        send_item(REQ_HIST, 8'd0, 6'd63);
        send_item(REQ_HIST, 8'd0, 6'd0);
        send_item(REQ_PAT, 8'd0, 6'd0);
        send_item(REQ_PAT, 8'd0, 6'd42);
        // Length lowered mid-read
        set_len(64);
        repeat (10) send_item(REQ_CHAR, BASE_N, 6'd0);
        set_len(4);
        send_item(REQ_CHAR, 8'd65, 6'd0);

        // Random phases across lengths; small lengths fill the pattern table
        foreach (lens[k]) begin
            set_len(lens[k]);
            if (k == 2) hold_off = 1;
            for (int n = 0; n < 290; n++) begin
                p = $urandom_range(0, 99);
                if (p < 80) begin
                    send_read($urandom_range(0, 3) == 0 ? 0 : $urandom_range(5, 90));
                    n += cur_len - 1;
                end else if (p < 88) begin
                    send_item(REQ_HIST, 8'($urandom), 6'($urandom));
                end else if (p < 96) begin
                    send_item(REQ_PAT, 8'($urandom), 6'($urandom));
                end else begin
                    send_item(2'($urandom), 8'($urandom), 6'($urandom));
                end
            end
        end
        for (int i = 0; i < 64; i++) send_item(REQ_HIST, 8'd0, 6'(i));
        for (int i = 0; i < 34; i++) send_item(REQ_PAT, 8'd0, 6'(i));

        drain();
        if (errors == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end
endmodule

[files.f]
+incdir+hw/rtl
hw/rtl/abps_pkg.sv
hw/rtl/abps_cell.sv
hw/rtl/ambiguous_base_position_stats.sv
verif/ambiguous_base_position_stats_checker.sv
verif/ambiguous_base_position_stats_tb.sv
